// ----- hdl/lsnw_pkg.sv -----
// Shared widths, constants and payload types of the node weight pipeline.
`timescale 1ns / 1ps

package lsnw_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int WEIGHT_FRAC_BITS = 28;
   localparam int WEIGHT_W         = 32;
   localparam int NCELL            = 4;

   // Offsets, squares, sums of four and the 2x2 system terms.
   localparam int OFF_W = COORD_WIDTH + 1;
   localparam int SQ_W  = 2 * OFF_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int R_W   = OFF_W + 2;

   // Wide multiplier: the B operand is consumed one digit per stage.
   localparam int MUL_A_W    = SUM_W + R_W + 1;
   localparam int MUL_B_W    = SUM_W;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_DIG_W  = 14;
   localparam int MUL_STAGES = (MUL_B_W + MUL_DIG_W - 1) / MUL_DIG_W;

   // Numerators and the denominator of the weights.
   localparam int NUM_W = MUL_A_W + R_W + 2;

   // Quotient bits before saturation, and the divider stage count.
   localparam int QB         = WEIGHT_W + 1;
   localparam int DIV_STAGES = QB + 2;

   localparam int NSTAGE = 2 * MUL_STAGES + 6 + DIV_STAGES;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] node_x;
      logic signed [COORD_WIDTH-1:0] node_y;
      logic signed [COORD_WIDTH-1:0] center0_x;
      logic signed [COORD_WIDTH-1:0] center0_y;
      logic signed [COORD_WIDTH-1:0] center1_x;
      logic signed [COORD_WIDTH-1:0] center1_y;
      logic signed [COORD_WIDTH-1:0] center2_x;
      logic signed [COORD_WIDTH-1:0] center2_y;
      logic signed [COORD_WIDTH-1:0] center3_x;
      logic signed [COORD_WIDTH-1:0] center3_y;
   } req_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight0;
      logic signed [WEIGHT_W-1:0] weight1;
      logic signed [WEIGHT_W-1:0] weight2;
      logic signed [WEIGHT_W-1:0] weight3;
      logic                       singular;
   } rsp_type;

   typedef struct packed {
      logic [NCELL-1:0][OFF_W-1:0] a;
      logic [NCELL-1:0][OFF_W-1:0] b;
      logic [R_W-1:0]              rx;
      logic [R_W-1:0]              ry;
   } carry_a_type;

   typedef struct packed {
      logic [NUM_W-1:0] d;
      logic             dz;
   } carry_b_type;

endpackage

// ----- hdl/least_squares_node_weights.sv -----
// Top level: least-squares cell-to-node interpolation weights, one node per transfer.
`timescale 1ns / 1ps

// This block takes one grid node and the centres of its four surrounding cells
// (signed Q16.16) per transfer and returns the four least-squares interpolation
// weights in signed Q4.28, rounded to nearest with ties away from zero and
// saturated, plus a singular flag that zeroes the weights when the system or the
// final denominator vanishes. A new node can be accepted on every clock cycle
// unless a result held at the output is not taken, so the sustained rate is one
// item per cycle. The pipeline holds 51 register stages, most of them in two
// chains of five-stage digit-serial multipliers and in the 33-step restoring
// divider that develops each weight one quotient bit per stage.
// The whole pipeline advances together whenever the output register is empty or
// is being emptied, so a stalled result holds everything behind it without loss.

module least_squares_node_weights import lsnw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Pipeline advance and valid bits.
   logic              en;
   logic [NSTAGE-1:0] vld_ff;

   assign en        = !vld_ff[NSTAGE-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid && req_ready};
      end
   end

   // Stage 1: offsets of each cell centre from the node.
   logic signed [COORD_WIDTH-1:0] cx [NCELL];
   logic signed [COORD_WIDTH-1:0] cy [NCELL];
   logic signed [OFF_W-1:0]       a1_ff [NCELL];
   logic signed [OFF_W-1:0]       b1_ff [NCELL];

   assign cx[0] = req_data.center0_x;
   assign cy[0] = req_data.center0_y;
   assign cx[1] = req_data.center1_x;
   assign cy[1] = req_data.center1_y;
   assign cx[2] = req_data.center2_x;
   assign cy[2] = req_data.center2_y;
   assign cx[3] = req_data.center3_x;
   assign cy[3] = req_data.center3_y;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NCELL; k++) begin
            a1_ff[k] <= OFF_W'(cx[k]) - OFF_W'(req_data.node_x);
            b1_ff[k] <= OFF_W'(cy[k]) - OFF_W'(req_data.node_y);
         end
      end
   end

   // Stage 2: squares and cross products of the offsets.
   logic signed [SQ_W-1:0]  aa2_ff [NCELL];
   logic signed [SQ_W-1:0]  bb2_ff [NCELL];
   logic signed [SQ_W-1:0]  ab2_ff [NCELL];
   logic signed [OFF_W-1:0] a2_ff  [NCELL];
   logic signed [OFF_W-1:0] b2_ff  [NCELL];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NCELL; k++) begin
            aa2_ff[k] <= SQ_W'(a1_ff[k]) * SQ_W'(a1_ff[k]);
            bb2_ff[k] <= SQ_W'(b1_ff[k]) * SQ_W'(b1_ff[k]);
            ab2_ff[k] <= SQ_W'(a1_ff[k]) * SQ_W'(b1_ff[k]);
            a2_ff[k]  <= a1_ff[k];
            b2_ff[k]  <= b1_ff[k];
         end
      end
   end

   // Stage 3: the moment sums of the system.
   logic signed [SUM_W-1:0] ixx_in, iyy_in, ixy_in;
   logic signed [R_W-1:0]   rx_in, ry_in;
   logic signed [SUM_W-1:0] ixx3_ff, iyy3_ff, ixy3_ff;
   carry_a_type             c3_ff;

   always_comb begin
      ixx_in = '0;
      iyy_in = '0;
      ixy_in = '0;
      rx_in  = '0;
      ry_in  = '0;
      for (int k = 0; k < NCELL; k++) begin
         ixx_in = ixx_in + SUM_W'(aa2_ff[k]);
         iyy_in = iyy_in + SUM_W'(bb2_ff[k]);
         ixy_in = ixy_in + SUM_W'(ab2_ff[k]);
         rx_in  = rx_in + R_W'(a2_ff[k]);
         ry_in  = ry_in + R_W'(b2_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ixx3_ff <= ixx_in;
         iyy3_ff <= iyy_in;
         ixy3_ff <= ixy_in;
         for (int k = 0; k < NCELL; k++) begin
            c3_ff.a[k] <= a2_ff[k];
            c3_ff.b[k] <= b2_ff[k];
         end
         c3_ff.rx <= rx_in;
         c3_ff.ry <= ry_in;
      end
   end

   // Stages 4 to 8: the determinant terms and the multiplier numerators.
   logic signed [MUL_P_W-1:0] p_iixx, p_ixyxy, p_ryxy, p_rxyy, p_rxxy, p_ryxx;

   lsnw_mul u_mul_xxyy (.clock(clock), .en(en), .a(MUL_A_W'(ixx3_ff)),
                        .b(MUL_B_W'(iyy3_ff)), .p(p_iixx));
   lsnw_mul u_mul_xyxy (.clock(clock), .en(en), .a(MUL_A_W'(ixy3_ff)),
                        .b(MUL_B_W'(ixy3_ff)), .p(p_ixyxy));
   lsnw_mul u_mul_ryxy (.clock(clock), .en(en), .a(MUL_A_W'(ixy3_ff)),
                        .b(MUL_B_W'($signed(c3_ff.ry))), .p(p_ryxy));
   lsnw_mul u_mul_rxyy (.clock(clock), .en(en), .a(MUL_A_W'(iyy3_ff)),
                        .b(MUL_B_W'($signed(c3_ff.rx))), .p(p_rxyy));
   lsnw_mul u_mul_rxxy (.clock(clock), .en(en), .a(MUL_A_W'(ixy3_ff)),
                        .b(MUL_B_W'($signed(c3_ff.rx))), .p(p_rxxy));
   lsnw_mul u_mul_ryxx (.clock(clock), .en(en), .a(MUL_A_W'(ixx3_ff)),
                        .b(MUL_B_W'($signed(c3_ff.ry))), .p(p_ryxx));

   carry_a_type ca_ff [MUL_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         ca_ff[0] <= c3_ff;
         for (int s = 1; s < MUL_STAGES; s++) begin
            ca_ff[s] <= ca_ff[s-1];
         end
      end
   end

   // Stage 9: determinant and the scaled multipliers Px and Py.
   logic signed [NUM_W-1:0]   d_in;
   logic signed [NUM_W-1:0]   d9_ff;
   logic                      dz9_ff;
   logic signed [MUL_A_W-1:0] px9_ff, py9_ff;
   carry_a_type               c9_ff;

   assign d_in = NUM_W'(p_iixx - p_ixyxy);

   always_ff @(posedge clock) begin
      if (en) begin
         d9_ff  <= d_in;
         dz9_ff <= d_in == '0;
         px9_ff <= MUL_A_W'(p_ryxy - p_rxyy);
         py9_ff <= MUL_A_W'(p_rxxy - p_ryxx);
         c9_ff  <= ca_ff[MUL_STAGES-1];
      end
   end

   // Stages 10 to 14: products of Px and Py with the sums and the offsets.
   logic signed [MUL_P_W-1:0] p_pxrx, p_pyry;
   logic signed [MUL_P_W-1:0] p_pxa [NCELL];
   logic signed [MUL_P_W-1:0] p_pyb [NCELL];

   lsnw_mul u_mul_pxrx (.clock(clock), .en(en), .a(px9_ff),
                        .b(MUL_B_W'($signed(c9_ff.rx))), .p(p_pxrx));
   lsnw_mul u_mul_pyry (.clock(clock), .en(en), .a(py9_ff),
                        .b(MUL_B_W'($signed(c9_ff.ry))), .p(p_pyry));

   genvar g;
   generate
      for (g = 0; g < NCELL; g++) begin : g_off_mul
         lsnw_mul u_mul_pxa (.clock(clock), .en(en), .a(px9_ff),
                             .b(MUL_B_W'($signed(c9_ff.a[g]))), .p(p_pxa[g]));
         lsnw_mul u_mul_pyb (.clock(clock), .en(en), .a(py9_ff),
                             .b(MUL_B_W'($signed(c9_ff.b[g]))), .p(p_pyb[g]));
      end
   endgenerate

   carry_b_type cb_ff [MUL_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         cb_ff[0].d  <= d9_ff;
         cb_ff[0].dz <= dz9_ff;
         for (int s = 1; s < MUL_STAGES; s++) begin
            cb_ff[s] <= cb_ff[s-1];
         end
      end
   end

   // Stage 15: the common denominator and the four numerators.
   logic signed [NUM_W-1:0] dd;
   logic signed [NUM_W-1:0] den15_ff;
   logic signed [NUM_W-1:0] num15_ff [NCELL];
   logic                    dz15_ff;

   assign dd = $signed(cb_ff[MUL_STAGES-1].d);

   always_ff @(posedge clock) begin
      if (en) begin
         den15_ff <= (dd <<< 2) + NUM_W'(p_pxrx) + NUM_W'(p_pyry);
         for (int k = 0; k < NCELL; k++) begin
            num15_ff[k] <= dd + NUM_W'(p_pxa[k]) + NUM_W'(p_pyb[k]);
         end
         dz15_ff <= cb_ff[MUL_STAGES-1].dz;
      end
   end

   // Stage 16: magnitudes, result signs and the singular test.
   logic [NUM_W-1:0] den16_ff;
   logic [NUM_W-1:0] num16_ff [NCELL];
   logic             neg16_ff [NCELL];
   logic             sing16_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den16_ff  <= den15_ff[NUM_W-1] ? NUM_W'(-den15_ff) : NUM_W'(den15_ff);
         sing16_ff <= dz15_ff || (den15_ff == '0);
         for (int k = 0; k < NCELL; k++) begin
            num16_ff[k] <= num15_ff[k][NUM_W-1] ? NUM_W'(-num15_ff[k])
                                                : NUM_W'(num15_ff[k]);
            neg16_ff[k] <= num15_ff[k][NUM_W-1] ^ den15_ff[NUM_W-1];
         end
      end
   end

   // Stages 17 onwards: one divider lane per weight; the flag keeps pace beside them.
   logic signed [WEIGHT_W-1:0] w [NCELL];

   generate
      for (g = 0; g < NCELL; g++) begin : g_div
         lsnw_div u_div (
            .clock   (clock),
            .en      (en),
            .num_mag (num16_ff[g]),
            .den_mag (den16_ff),
            .neg     (neg16_ff[g]),
            .zero    (sing16_ff),
            .weight  (w[g])
         );
      end
   endgenerate

   logic sing_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= sing16_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   assign rsp_data.weight0  = w[0];
   assign rsp_data.weight1  = w[1];
   assign rsp_data.weight2  = w[2];
   assign rsp_data.weight3  = w[3];
   assign rsp_data.singular = sing_ff[DIV_STAGES-1];

endmodule

// ----- hdl/lsnw_mul.sv -----
// Pipelined signed multiplier that takes one digit of the B operand per stage.
`timescale 1ns / 1ps

module lsnw_mul import lsnw_pkg::*; (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [MUL_A_W-1:0]  a,
   input  logic signed [MUL_B_W-1:0]  b,
   output logic signed [MUL_P_W-1:0]  p
);

   localparam int BX_W = MUL_STAGES * MUL_DIG_W;
   localparam int PP_W = MUL_A_W + MUL_DIG_W + 1;

   logic signed [MUL_A_W-1:0] a_ff   [MUL_STAGES];
   logic signed [BX_W-1:0]    b_ff   [MUL_STAGES];
   logic signed [MUL_P_W-1:0] acc_ff [MUL_STAGES];

   genvar s;
   generate
      for (s = 0; s < MUL_STAGES; s++) begin : g_stage
         logic signed [MUL_A_W-1:0] a_src;
         logic signed [BX_W-1:0]    b_src;
         logic signed [MUL_P_W-1:0] acc_src;
         logic [MUL_DIG_W-1:0]      dig;
         logic signed [PP_W-1:0]    dig_ext;
         logic signed [PP_W-1:0]    part;
         logic signed [MUL_P_W-1:0] acc_in;

         if (s == 0) begin : g_first
            assign a_src   = a;
            assign b_src   = BX_W'(b);
            assign acc_src = '0;
         end else begin : g_next
            assign a_src   = a_ff[s-1];
            assign b_src   = b_ff[s-1];
            assign acc_src = acc_ff[s-1];
         end

         assign dig = b_src[s*MUL_DIG_W +: MUL_DIG_W];

         // The top digit carries the sign of B, the lower ones are plain magnitudes.
         if (s == MUL_STAGES - 1) begin : g_top
            assign dig_ext = PP_W'($signed(dig));
         end else begin : g_low
            assign dig_ext = PP_W'($signed({1'b0, dig}));
         end

         assign part   = PP_W'(a_src) * dig_ext;
         assign acc_in = acc_src + (MUL_P_W'(part) <<< (s * MUL_DIG_W));

         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[s]   <= a_src;
               b_ff[s]   <= b_src;
               acc_ff[s] <= acc_in;
            end
         end
      end
   endgenerate

   assign p = acc_ff[MUL_STAGES-1];

endmodule

// ----- hdl/lsnw_div.sv -----
// Pipelined restoring divider with rounding, saturation and sign for one weight.
`timescale 1ns / 1ps

module lsnw_div import lsnw_pkg::*; (
   input  logic                       clock,
   input  logic                       en,
   input  logic [NUM_W-1:0]           num_mag,
   input  logic [NUM_W-1:0]           den_mag,
   input  logic                       neg,
   input  logic                       zero,
   output logic signed [WEIGHT_W-1:0] weight
);

   localparam int RW = NUM_W + QB + 1;
   localparam logic [QB:0] SAT_POS = (QB+1)'((64'd1 << (WEIGHT_W - 1)) - 64'd1);
   localparam logic [QB:0] SAT_NEG = (QB+1)'(64'd1 << (WEIGHT_W - 1));

   logic [RW-1:0]    rem_ff  [QB+1];
   logic [QB-1:0]    q_ff    [QB+1];
   logic [NUM_W-1:0] den_ff  [QB+1];
   logic             neg_ff  [QB+1];
   logic             zero_ff [QB+1];
   logic             big_ff  [QB+1];
   logic [WEIGHT_W-1:0] weight_ff;

   logic [RW-1:0] rem0_in;
   logic          big0_in;

   // A quotient of 2^QB or more always saturates, so only QB bits are developed.
   assign rem0_in = RW'(num_mag) << WEIGHT_FRAC_BITS;
   assign big0_in = rem0_in >= (RW'(den_mag) << QB);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem0_in;
         q_ff[0]    <= '0;
         den_ff[0]  <= den_mag;
         neg_ff[0]  <= neg;
         zero_ff[0] <= zero;
         big_ff[0]  <= big0_in;
      end
   end

   genvar t;
   generate
      for (t = 1; t <= QB; t++) begin : g_step
         localparam int J = QB - t;
         logic [RW-1:0] sub;
         logic          take;

         assign sub  = RW'(den_ff[t-1]) << J;
         assign take = rem_ff[t-1] >= sub;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[t]  <= take ? rem_ff[t-1] - sub : rem_ff[t-1];
               q_ff[t]    <= q_ff[t-1] | (QB'(take) << J);
               den_ff[t]  <= den_ff[t-1];
               neg_ff[t]  <= neg_ff[t-1];
               zero_ff[t] <= zero_ff[t-1];
               big_ff[t]  <= big_ff[t-1];
            end
         end
      end
   endgenerate

   logic          round_up;
   logic [QB:0]   q_rnd;
   logic [QB:0]   bound;
   logic [QB:0]   mag;
   logic [WEIGHT_W-1:0] weight_in;

   // Round to nearest, ties away from zero, then clamp to the signed range.
   assign round_up  = {rem_ff[QB], 1'b0} >= (RW+1)'(den_ff[QB]);
   assign q_rnd     = {1'b0, q_ff[QB]} + (QB+1)'(round_up);
   assign bound     = neg_ff[QB] ? SAT_NEG : SAT_POS;
   assign mag       = (big_ff[QB] || (q_rnd > bound)) ? bound : q_rnd;
   assign weight_in = zero_ff[QB] ? '0 :
                      neg_ff[QB]  ? WEIGHT_W'(-mag) : WEIGHT_W'(mag);

   always_ff @(posedge clock) begin
      if (en) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = $signed(weight_ff);

endmodule

// ----- tb/sv/tb_least_squares_node_weights.sv -----
// Self-checking testbench for the least-squares node weight pipeline.
`timescale 1ns / 1ps

module tb_least_squares_node_weights;
   import lsnw_pkg::*;

   // All system terms are worked out in 256-bit two's complement, which is
   // ample headroom for the products of the 2x2 solve and the shifted numerator.
   typedef logic signed [255:0] wide_t;

   localparam int LATENCY_WAIT = NSTAGE + 10;
   localparam int WATCHDOG_MAX = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Handshake values sampled mid-cycle, so that a transfer at the next rising
   // edge is judged without regard to the order of events within that step.
   logic    req_ready_seen = 1'b0;
   logic    rsp_valid_seen = 1'b0;
   rsp_type rsp_data_seen = '0;

   rsp_type pending_weights[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      burst_left = 0;

   always #2 clock = ~clock;

   least_squares_node_weights DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always @(negedge clock) begin
      req_ready_seen <= req_ready;
      rsp_valid_seen <= rsp_valid;
      rsp_data_seen  <= rsp_data;
   end

   // Weight of one cell: numerator over denominator, scaled to the output
   // fraction, rounded to nearest with ties away from zero, then saturated.
   function automatic logic [WEIGHT_W-1:0] weight_of(wide_t num, wide_t den);
      logic [255:0]          n_mag;
      logic [255:0]          d_mag;
      logic [255:0]          quo;
      logic [255:0]          rem;
      logic                  neg;
      logic [WEIGHT_W-1:0]   bound;
      logic [WEIGHT_W-1:0]   mag;
      neg   = num[255] ^ den[255];
      n_mag = num[255] ? -num : num;
      d_mag = den[255] ? -den : den;
      n_mag = n_mag << WEIGHT_FRAC_BITS;
      quo   = n_mag / d_mag;
      rem   = n_mag % d_mag;
      if ((rem << 1) >= d_mag) begin
         quo = quo + 1;
      end
      bound = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag   = (quo > {224'b0, bound}) ? bound : quo[WEIGHT_W-1:0];
      return neg ? -mag : mag;
   endfunction

   // Expected result for one node: offsets, moment sums, the solve multiplied
   // through by the determinant, and the four weights over a common denominator.
   function automatic rsp_type node_weights(req_type node);
      wide_t   nx, ny, ixx, iyy, ixy, sx, sy, det, px, py, den;
      wide_t   ax[NCELL];
      wide_t   by[NCELL];
      wide_t   cx[NCELL];
      wide_t   cy[NCELL];
      rsp_type res;
      nx = node.node_x;
      ny = node.node_y;
      cx[0] = node.center0_x;  cy[0] = node.center0_y;
      cx[1] = node.center1_x;  cy[1] = node.center1_y;
      cx[2] = node.center2_x;  cy[2] = node.center2_y;
      cx[3] = node.center3_x;  cy[3] = node.center3_y;
      ixx = 0; iyy = 0; ixy = 0; sx = 0; sy = 0;
      for (int k = 0; k < NCELL; k++) begin
         ax[k] = cx[k] - nx;
         by[k] = cy[k] - ny;
         ixx += ax[k] * ax[k];
         iyy += by[k] * by[k];
         ixy += ax[k] * by[k];
         sx  += ax[k];
         sy  += by[k];
      end
      det = ixx * iyy - ixy * ixy;
      px  = sy * ixy - sx * iyy;
      py  = sx * ixy - sy * ixx;
      den = 4 * det + px * sx + py * sy;
      res = '0;
      if (det == 0 || den == 0) begin
         res.singular = 1'b1;
      end else begin
         res.weight0 = weight_of(det + px * ax[0] + py * by[0], den);
         res.weight1 = weight_of(det + px * ax[1] + py * by[1], den);
         res.weight2 = weight_of(det + px * ax[2] + py * by[2], den);
         res.weight3 = weight_of(det + px * ax[3] + py * by[3], den);
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("mismatch on %s: expected %h, got %h at %0t", field, want, got, $realtime);
      mismatches++;
   endtask

   // Sends one node. The sender works in bursts; between bursts valid usually drops
   // for a random number of cycles. The expectation is queued at the transfer.
   task automatic send_node(req_type node);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= node;
      @(posedge clock);
      while (!req_ready_seen) @(posedge clock);
      pending_weights.push_back(node_weights(node));
   endtask

   function automatic req_type make_node(int nx, int ny, int c[8]);
      req_type node;
      node.node_x = nx;      node.node_y = ny;
      node.center0_x = c[0]; node.center0_y = c[1];
      node.center1_x = c[2]; node.center1_y = c[3];
      node.center2_x = c[4]; node.center2_y = c[5];
      node.center3_x = c[6]; node.center3_y = c[7];
      return node;
   endfunction

   // Hand-picked nodes: the regular grid, singular layouts and the coordinate
   // extremes, where offsets reach 33 bits and weights are likely to saturate.
   task automatic test_directed();
      int h;
      h = 32'h0000_8000;
      send_node(make_node(0, 0, '{-h, h, h, h, -h, -h, h, -h}));
      send_node(make_node(32'h0001_0000, 32'h0002_0000,
                          '{32'h0000_8000, 32'h0002_8000, 32'h0001_8000, 32'h0002_8000,
                            32'h0000_8000, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000}));
      // Off-centre node: weights differ from a quarter and some go negative.
      send_node(make_node(32'h0003_0000, -32'h0002_0000, '{-h, h, h, h, -h, -h, h, -h}));
      // Every offset zero.
      send_node(make_node(0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}));
      send_node(make_node(32'h7FFF_FFFF, 32'h8000_0000,
                          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}));
      // Collinear centres: the determinant vanishes.
      send_node(make_node(0, 0, '{h, h, 2 * h, 2 * h, -h, -h, 3 * h, 3 * h}));
      send_node(make_node(0, 0, '{h, 0, 2 * h, 0, -h, 0, 5 * h, 0}));
      // Two distinct points only.
      send_node(make_node(0, 0, '{h, 0, h, 0, 0, h, 0, h}));
      send_node(make_node(32'h8000_0000, 32'h8000_0000,
                          '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}));
      send_node(make_node(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}));
      // Node far outside a tiny cell cluster: extrapolation drives saturation.
      send_node(make_node(32'h7FFF_0000, 32'h7FFF_0000, '{-1, 1, 1, 1, -1, -1, 1, -1}));
      send_node(make_node(32'h8000_0000, 32'h7FFF_FFFF, '{0, 1, 1, 0, -1, 0, 0, -1}));
      send_node(make_node(32'hFFFF_FFFF, 32'h0000_0001,
                          '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'hF0F0_F0F0, 32'h0F0F_0F0F}));
      send_node(make_node(0, 0, '{-1, 1, 1, 1, -1, -1, 1, -2}));
   endtask

   // Realistic nodes: a slightly distorted cell quad around the node at a
   // random scale and position, which is where the block spends its life.
   task automatic test_grid_nodes(int count);
      int nx, ny, hx, hy, j;
      int c[8];
      for (int i = 0; i < count; i++) begin
         nx = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
         ny = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
         hx = $urandom_range(1, 1 << $urandom_range(1, 28));
         hy = $urandom_range(1, 1 << $urandom_range(1, 28));
         j  = (hx < hy ? hx : hy) / 3 + 1;
         c[0] = nx - hx; c[1] = ny + hy;
         c[2] = nx + hx; c[3] = ny + hy;
         c[4] = nx - hx; c[5] = ny - hy;
         c[6] = nx + hx; c[7] = ny - hy;
         for (int k = 0; k < 8; k++) begin
            c[k] += $urandom_range(0, 2 * j) - j;
         end
         send_node(make_node(nx, ny, c));
      end
   endtask

   // Arbitrary bit patterns on every field.
   task automatic test_random_bits(int count);
      int c[8];
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < 8; k++) begin
            c[k] = $urandom;
         end
         send_node(make_node($urandom, $urandom, c));
      end
   endtask

   // Collinear or coincident centres around random nodes, so the singular
   // path is taken often and with varied neighbours in the pipeline.
   task automatic test_degenerate(int count);
      int nx, ny, ux, uy, t;
      int c[8];
      for (int i = 0; i < count; i++) begin
         nx = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         ny = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         ux = $urandom_range(0, 4000) - 2000;
         uy = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4000) - 2000;
         for (int k = 0; k < NCELL; k++) begin
            t = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 2000) - 1000;
            c[2 * k]     = nx + t * ux;
            c[2 * k + 1] = ny + t * uy;
         end
         send_node(make_node(nx, ny, c));
      end
   endtask

   // The receiver steps through four behaviours in turn: always
   // ready, coin-flip, long stalls, and mostly ready with short hiccups.
   int stall_phase = 0;
   int stall_run   = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 1200;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_phase / 300)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_run <= $urandom_range(5, 30);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Result checker: each transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid_seen && rsp_ready) begin
         if (pending_weights.size() == 0) begin
            $display("unexpected result %h at %0t", rsp_data_seen, $realtime);
            mismatches++;
         end else begin
            want = pending_weights.pop_front();
            if (rsp_data_seen.weight0 !== want.weight0)
               report_mismatch("weight0", want.weight0, rsp_data_seen.weight0);
            if (rsp_data_seen.weight1 !== want.weight1)
               report_mismatch("weight1", want.weight1, rsp_data_seen.weight1);
            if (rsp_data_seen.weight2 !== want.weight2)
               report_mismatch("weight2", want.weight2, rsp_data_seen.weight2);
            if (rsp_data_seen.weight3 !== want.weight3)
               report_mismatch("weight3", want.weight3, rsp_data_seen.weight3);
            if (rsp_data_seen.singular !== want.singular)
               report_mismatch("singular", want.singular, rsp_data_seen.singular);
         end
      end
   end

   // Watchdog: too long without a transfer on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready_seen) || (rsp_valid_seen && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("[least_squares_node_weights] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int waited;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_grid_nodes(800);
      test_random_bits(380);
      test_degenerate(160);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_weights.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_weights.size() == 0) begin
         $display("[least_squares_node_weights] OK");
      end else begin
         $display("[least_squares_node_weights] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/lsnw_pkg.sv
hdl/lsnw_mul.sv
hdl/lsnw_div.sv
hdl/least_squares_node_weights.sv
tb/sv/tb_least_squares_node_weights.sv
